// File: design/weighted_3x3_blur_filter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the blur filter blocks.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_3X3_BLUR_FILTER_MACROS_SVH
`define WEIGHTED_3X3_BLUR_FILTER_MACROS_SVH

// same-cycle implication
`define WB3_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WB3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wb3_pkg.sv
// ----------------------------------------------------------------------------
// wb3_pkg
// Types and constants shared by the 3x3 binomial blur filter.
// ----------------------------------------------------------------------------
package wb3_pkg;

  localparam int PIX_W       = 24;
  localparam int ROW_W       = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] wb3_pix_t;

  typedef struct packed {
    logic valid;
    logic wr;
    logic emit;
    logic border;
    logic last;
  } wb3_tok_t;

  typedef struct packed {
    logic s1_emit;
    logic s2_emit;
  } wb3_flight_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
  } wb3_res_t;

endpackage

// File: design/wb3_ram.sv
// ----------------------------------------------------------------------------
// wb3_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/wb3_front.sv
// ----------------------------------------------------------------------------
// wb3_front
// Accepts words, classifies pixels and flush ticks, tracks frame position
// and issues the line store read.
// ----------------------------------------------------------------------------
module wb3_front
  import wb3_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic [AW-1:0]     w_m1,
  input  logic [ROW_W-1:0]  h_m1,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic [7:0]        red_in,
  input  logic [7:0]        green_in,
  input  logic [7:0]        blue_in,
  input  wb3_flight_t       flight,
  input  logic [QCNT_W-1:0] q_count,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  output wb3_tok_t          tok,
  output logic [AW-1:0]     tok_addr,
  output wb3_pix_t          tok_pix
);

  logic [AW-1:0]    in_col;
  logic [ROW_W-1:0] in_row;
  logic [AW-1:0]    out_col;
  logic [ROW_W-1:0] out_row;
  logic             draining;

  logic             accept;
  logic             live;
  logic             emit;
  logic             border;
  logic             last;
  logic             col_last;
  logic [QCNT_W:0]  pending;

  assign pending = {1'b0, q_count} + (QCNT_W+1)'(flight.s1_emit)
                 + (QCNT_W+1)'(flight.s2_emit);
  assign in_ready = pending < (QCNT_W+1)'(QUEUE_DEPTH);

  assign accept   = in_valid && in_ready;
  assign live     = accept && (draining || action == ACT_PIXEL);
  assign emit     = draining || (in_row >= ROW_W'(2))
                 || (in_row == ROW_W'(1) && in_col != '0);
  assign col_last = in_col == w_m1;
  assign border   = (out_row == '0) || (out_row == h_m1)
                 || (out_col == '0) || (out_col == w_m1);
  assign last     = (out_row == h_m1) && (out_col == w_m1);

  assign rd_en   = live;
  assign rd_addr = in_col;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col   <= '0;
      in_row   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      draining <= 1'b0;
      tok      <= '0;
    end else begin
      tok <= '{valid: live, wr: live && !draining, emit: live && emit,
               border: border, last: last};
      if (live) begin
        if (emit && last) begin
          in_col   <= '0;
          in_row   <= '0;
          out_col  <= '0;
          out_row  <= '0;
          draining <= 1'b0;
        end else begin
          in_col <= col_last ? '0 : in_col + AW'(1);
          if (col_last && !draining) begin
            if (in_row == h_m1) begin
              draining <= 1'b1;
            end else begin
              in_row <= in_row + ROW_W'(1);
            end
          end
          if (emit) begin
            if (out_col == w_m1) begin
              out_col <= '0;
              out_row <= out_row + ROW_W'(1);
            end else begin
              out_col <= out_col + AW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (live) begin
      tok_addr <= in_col;
      tok_pix  <= {blue_in, green_in, red_in};
    end
  end

endmodule

// File: design/wb3_window.sv
// ----------------------------------------------------------------------------
// wb3_window
// Updates the line stores and the 3x3 window, then forms the blurred or
// passed-through result.
// ----------------------------------------------------------------------------
module wb3_window
  import wb3_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  wb3_tok_t           tok,
  input  logic [AW-1:0]      tok_addr,
  input  wb3_pix_t           tok_pix,
  input  logic [2*PIX_W-1:0] rd_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [2*PIX_W-1:0] wr_data,
  output wb3_flight_t        flight,
  output logic               push,
  output wb3_res_t           push_res
);

  wb3_pix_t   win [9];
  wb3_pix_t   top;
  wb3_pix_t   mid;
  wb3_pix_t   bot;
  logic       s2_emit;
  logic       s2_border;
  logic       s2_last;
  logic [11:0] sum [3];

  assign top = rd_data[2*PIX_W-1:PIX_W];
  assign mid = rd_data[PIX_W-1:0];
  assign bot = tok.wr ? tok_pix : '0;

  assign wr_en   = tok.valid && tok.wr;
  assign wr_addr = tok_addr;
  assign wr_data = {mid, tok_pix};

  assign flight.s1_emit = tok.valid && tok.emit;
  assign flight.s2_emit = s2_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
      s2_emit <= 1'b0;
    end else begin
      s2_emit <= tok.valid && tok.emit;
      if (tok.valid) begin
        for (int k = 0; k < 3; k++) begin
          win[k*3]   <= win[k*3+1];
          win[k*3+1] <= win[k*3+2];
        end
        win[2] <= top;
        win[5] <= mid;
        win[8] <= bot;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_border <= tok.border;
    s2_last   <= tok.last;
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = 12'(win[0][ch*8 +: 8]) + 12'(win[2][ch*8 +: 8])
              + 12'(win[6][ch*8 +: 8]) + 12'(win[8][ch*8 +: 8])
              + {3'b0, win[1][ch*8 +: 8], 1'b0} + {3'b0, win[3][ch*8 +: 8], 1'b0}
              + {3'b0, win[5][ch*8 +: 8], 1'b0} + {3'b0, win[7][ch*8 +: 8], 1'b0}
              + {2'b0, win[4][ch*8 +: 8], 2'b0};
    end
  end

  assign push               = s2_emit;
  assign push_res.red       = s2_border ? win[4][7:0]   : sum[0][11:4];
  assign push_res.green     = s2_border ? win[4][15:8]  : sum[1][11:4];
  assign push_res.blue      = s2_border ? win[4][23:16] : sum[2][11:4];
  assign push_res.frame_end = s2_last;

endmodule

// File: design/wb3_back.sv
// ----------------------------------------------------------------------------
// wb3_back
// Result queue feeding the output channel.
// ----------------------------------------------------------------------------
`include "weighted_3x3_blur_filter_macros.svh"

module wb3_back
  import wb3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wb3_res_t          push_res,
  output logic [QCNT_W-1:0] count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        red_out,
  output logic [7:0]        green_out,
  output logic [7:0]        blue_out,
  output logic              frame_end
);

  wb3_res_t          q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic              pop;
  wb3_res_t          head_res;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign head_res  = q[head];
  assign red_out   = head_res.red;
  assign green_out = head_res.green;
  assign blue_out  = head_res.blue;
  assign frame_end = head_res.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + QPTR_W'(1);
      end
      if (pop) begin
        head <= head + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= push_res;
    end
  end

  `WB3_ASSERT_SAME(a_no_overflow, clk, rst, push && count == QCNT_FULL, pop, "queue overflow")
  `WB3_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + QCNT_W'(1), "count up")
  `WB3_ASSERT_NEXT(a_count_dn, clk, rst, pop && !push, count == $past(count) - QCNT_W'(1), "count dn")

endmodule

// File: design/weighted_3x3_blur_filter.sv
// ----------------------------------------------------------------------------
// weighted_3x3_blur_filter
// 3x3 binomial blur over a raster RGB stream with border pass-through.
// ----------------------------------------------------------------------------
// channel  signals                                  role
// input    in_valid/in_ready action red/green/blue  pixel or flush word
// output   out_valid/out_ready red/green/blue/end   filtered pixel word
// config   APB psel/penable/pwrite/paddr/pwdata     width, height registers
//
// One word per cycle while in_ready is high; results pass the token stage,
// window stage and result queue. The line stores share one 48-bit RAM, read
// for accepted pixel and drain words, written back in the next cycle. in_ready
// falls when the four-entry queue plus two in-flight stages would overflow.
// Synchronous reset; no clearing pass. A register write restarts the frame.
// ----------------------------------------------------------------------------
module weighted_3x3_blur_filter
  import wb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        frame_end
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [10:0]        image_width;
  logic [12:0]        image_height;
  logic               cfg_wr;
  logic [AW-1:0]      w_m1;
  logic [ROW_W-1:0]   h_m1;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [2*PIX_W-1:0] rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [2*PIX_W-1:0] wr_data;
  wb3_tok_t           tok;
  logic [AW-1:0]      tok_addr;
  wb3_pix_t           tok_pix;
  wb3_flight_t        flight;
  logic               push;
  wb3_res_t           push_res;
  logic [QCNT_W-1:0]  q_count;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd640;
      image_height <= 13'd480;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[10:0];
        REG_HEIGHT: image_height <= pwdata[12:0];
        default:    image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {21'b0, image_width};
      REG_HEIGHT: prdata = {19'b0, image_height};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    priority if (image_width < 11'd3) begin
      w_m1 = AW'(2);
    end else if ({21'b0, image_width} > 32'(MAX_WIDTH)) begin
      w_m1 = AW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = AW'(image_width - 11'd1);
    end
  end

  always_comb begin
    priority if (image_height < 13'd3) begin
      h_m1 = ROW_W'(2);
    end else if (image_height > 13'd4096) begin
      h_m1 = ROW_W'(4095);
    end else begin
      h_m1 = ROW_W'(image_height - 13'd1);
    end
  end

  wb3_front #(.AW(AW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_wr),
    .w_m1     (w_m1),
    .h_m1     (h_m1),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .flight   (flight),
    .q_count  (q_count),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .tok      (tok),
    .tok_addr (tok_addr),
    .tok_pix  (tok_pix)
  );

  wb3_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH), .AW(AW)) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wb3_window #(.AW(AW)) u_window (
    .clk      (clk),
    .rst      (rst),
    .tok      (tok),
    .tok_addr (tok_addr),
    .tok_pix  (tok_pix),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .flight   (flight),
    .push     (push),
    .push_res (push_res)
  );

  wb3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .count     (q_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .frame_end (frame_end)
  );

endmodule
